/* hdl/svang_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svang_pkg
// Shared widths, types and the arc tangent step table for the sun vector
// angle pipeline.
// ----------------------------------------------------------------------------
package svang_pkg;

	localparam int SAMPLE_BITS  = 10;
	localparam int LANES        = 5;
	localparam int SX_W         = SAMPLE_BITS + 1;
	localparam int SQ_W         = 2 * SX_W;
	localparam int SUM_W        = SQ_W + 2;
	localparam int RAD_W        = SUM_W + 16;
	localparam int ROOT_W       = RAD_W / 2;
	localparam int MREM_W       = ROOT_W + 2;
	localparam int R_W          = ROOT_W + 1;
	localparam int Q_W          = 16;
	localparam int CRAD_W       = 34;
	localparam int CROOT_W      = 17;
	localparam int CREM_W       = CROOT_W + 2;
	localparam int CORDIC_STEPS = 17;
	localparam int CV_W         = 20;
	localparam int Z_W          = 19;
	localparam int SCALE_W      = 13;
	localparam int PROD_W       = Z_W - 1 + SCALE_W;
	localparam int ANGLE_W      = 14;
	localparam logic [SCALE_W-1:0] SCALE     = 13'd5729;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX = 14'd9000;
	localparam int MAG_LAT      = 2 + ROOT_W;
	localparam int LANE_LAT     = 1 + Q_W + 2 + CROOT_W + CORDIC_STEPS + 2;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [LANES-1:0][SAMPLE_BITS-1:0] sample_vec_t;

	typedef struct packed {
		logic              vld;
		logic [ROOT_W-1:0] root;
		sample_vec_t       smp;
	} mag_out_t;

	function automatic logic signed [Z_W-1:0] step_angle(input logic [4:0] i);
		logic signed [Z_W-1:0] a;
		unique case (i)
			5'd0:    a = 19'sd51472;
			5'd1:    a = 19'sd30386;
			5'd2:    a = 19'sd16055;
			5'd3:    a = 19'sd8150;
			5'd4:    a = 19'sd4091;
			5'd5:    a = 19'sd2047;
			5'd6:    a = 19'sd1024;
			5'd7:    a = 19'sd512;
			5'd8:    a = 19'sd256;
			5'd9:    a = 19'sd128;
			5'd10:   a = 19'sd64;
			5'd11:   a = 19'sd32;
			5'd12:   a = 19'sd16;
			5'd13:   a = 19'sd8;
			5'd14:   a = 19'sd4;
			5'd15:   a = 19'sd2;
			5'd16:   a = 19'sd1;
			default: a = 19'sd0;
		endcase
		return a;
	endfunction

endpackage

/* hdl/svang_mag.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svang_mag
// Sum of squares of the sun vector and its square root in Q.8, one root
// bit per stage; the samples travel alongside.
// ----------------------------------------------------------------------------
module svang_mag (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  svang_pkg::sample_vec_t smp,
	output svang_pkg::mag_out_t    mo
);

	logic [svang_pkg::SX_W-1:0]  sx, sy;
	logic                        vld_s1, vld_s2;
	logic [svang_pkg::SQ_W-1:0]  sqx_s1, sqy_s1, sqz_s1;
	svang_pkg::sample_vec_t      smp_s1, smp_s2;
	logic [svang_pkg::SUM_W-1:0] sum_s2;

	logic                         vld_s3  [svang_pkg::ROOT_W];
	logic [svang_pkg::RAD_W-1:0]  rad_s3  [svang_pkg::ROOT_W];
	logic [svang_pkg::MREM_W-1:0] rem_s3  [svang_pkg::ROOT_W];
	logic [svang_pkg::ROOT_W-1:0] root_s3 [svang_pkg::ROOT_W];
	svang_pkg::sample_vec_t       smp_s3  [svang_pkg::ROOT_W];

	assign sx = {1'b0, smp[0]} + {1'b0, smp[3]};
	assign sy = {1'b0, smp[1]} + {1'b0, smp[4]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1 <= sx * sx;
			sqy_s1 <= sy * sy;
			sqz_s1 <= {1'b0, smp[2]} * {1'b0, smp[2]};
			smp_s1 <= smp;
			sum_s2 <= {2'b00, sqx_s1} + {2'b00, sqy_s1} + {2'b00, sqz_s1};
			smp_s2 <= smp_s1;
		end
	end

	for (genvar k = 0; k < svang_pkg::ROOT_W; k++) begin : g_sqrt
		logic                         vi;
		logic [svang_pkg::RAD_W-1:0]  ri;
		logic [svang_pkg::MREM_W-1:0] mi, mn, tr;
		logic [svang_pkg::ROOT_W-1:0] oi;
		svang_pkg::sample_vec_t       si;

		if (k == 0) begin : g_first
			assign vi = vld_s2;
			assign ri = {sum_s2, 16'h0000};
			assign mi = '0;
			assign oi = '0;
			assign si = smp_s2;
		end else begin : g_next
			assign vi = vld_s3[k-1];
			assign ri = rad_s3[k-1];
			assign mi = rem_s3[k-1];
			assign oi = root_s3[k-1];
			assign si = smp_s3[k-1];
		end

		assign mn = {mi[svang_pkg::MREM_W-3:0], ri[svang_pkg::RAD_W-1 -: 2]};
		assign tr = {oi, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s3[k] <= 1'b0;
			end else if (en) begin
				vld_s3[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s3[k] <= {ri[svang_pkg::RAD_W-3:0], 2'b00};
				smp_s3[k] <= si;
				if (mn >= tr) begin
					rem_s3[k]  <= mn - tr;
					root_s3[k] <= {oi[svang_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_s3[k]  <= mn;
					root_s3[k] <= {oi[svang_pkg::ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign mo.vld  = vld_s3[svang_pkg::ROOT_W-1];
	assign mo.root = root_s3[svang_pkg::ROOT_W-1];
	assign mo.smp  = smp_s3[svang_pkg::ROOT_W-1];

endmodule

/* hdl/svang_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svang_lane
// One angle: ratio by restoring division, complement by square root,
// arc tangent by vectoring CORDIC, then scaling to hundredths of a degree.
// ----------------------------------------------------------------------------
module svang_lane (
	input  logic                            clk,
	input  logic                            en,
	input  logic [svang_pkg::ROOT_W-1:0]    root,
	input  svang_pkg::sample_t              smp,
	output logic [svang_pkg::ANGLE_W-1:0]   angle
);

	logic [svang_pkg::R_W-1:0]   r_s1;
	logic [svang_pkg::R_W:0]     part_s1;

	logic [svang_pkg::R_W-1:0]   r_s2    [svang_pkg::Q_W];
	logic [svang_pkg::R_W:0]     part_s2 [svang_pkg::Q_W];
	logic [svang_pkg::Q_W-1:0]   q_s2    [svang_pkg::Q_W];

	logic [2*svang_pkg::Q_W-1:0] sq_s3;
	logic [svang_pkg::CRAD_W-1:0] rad_s4;

	logic [svang_pkg::Q_W-1:0]     q_s5    [svang_pkg::CROOT_W];
	logic [svang_pkg::CRAD_W-1:0]  rad_s5  [svang_pkg::CROOT_W];
	logic [svang_pkg::CREM_W-1:0]  rem_s5  [svang_pkg::CROOT_W];
	logic [svang_pkg::CROOT_W-1:0] root_s5 [svang_pkg::CROOT_W];
	logic [svang_pkg::Q_W-1:0]     q_s4;

	logic signed [svang_pkg::CV_W-1:0] x_s6 [svang_pkg::CORDIC_STEPS];
	logic signed [svang_pkg::CV_W-1:0] y_s6 [svang_pkg::CORDIC_STEPS];
	logic signed [svang_pkg::Z_W-1:0]  z_s6 [svang_pkg::CORDIC_STEPS];

	logic signed [svang_pkg::Z_W-1:0] zf;
	logic [svang_pkg::Z_W-2:0]        zc;
	logic [svang_pkg::PROD_W-1:0]     prod_s7;
	logic [svang_pkg::PROD_W-17:0]    deg;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= {1'b0, root} + svang_pkg::R_W'(256);
			part_s1 <= (svang_pkg::R_W+1)'({smp, 8'h00});
		end
	end

	for (genvar j = 0; j < svang_pkg::Q_W; j++) begin : g_div
		logic [svang_pkg::R_W-1:0] ri;
		logic [svang_pkg::R_W:0]   pi, p2;
		logic [svang_pkg::Q_W-1:0] qi;

		if (j == 0) begin : g_first
			assign ri = r_s1;
			assign pi = part_s1;
			assign qi = '0;
		end else begin : g_next
			assign ri = r_s2[j-1];
			assign pi = part_s2[j-1];
			assign qi = q_s2[j-1];
		end

		assign p2 = {pi[svang_pkg::R_W-1:0], 1'b0};

		always_ff @(posedge clk) begin
			if (en) begin
				r_s2[j] <= ri;
				if (p2 >= {1'b0, ri}) begin
					part_s2[j] <= p2 - {1'b0, ri};
					q_s2[j]    <= {qi[svang_pkg::Q_W-2:0], 1'b1};
				end else begin
					part_s2[j] <= p2;
					q_s2[j]    <= {qi[svang_pkg::Q_W-2:0], 1'b0};
				end
			end
		end
	end

	logic [svang_pkg::Q_W-1:0] q_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3  <= q_s2[svang_pkg::Q_W-1] * q_s2[svang_pkg::Q_W-1];
			q_s3   <= q_s2[svang_pkg::Q_W-1];
			rad_s4 <= {2'b01, 32'h0} - {2'b00, sq_s3};
			q_s4   <= q_s3;
		end
	end

	for (genvar k = 0; k < svang_pkg::CROOT_W; k++) begin : g_csqrt
		logic [svang_pkg::CRAD_W-1:0]  ri;
		logic [svang_pkg::CREM_W-1:0]  mi, mn, tr;
		logic [svang_pkg::CROOT_W-1:0] oi;
		logic [svang_pkg::Q_W-1:0]     qi;

		if (k == 0) begin : g_first
			assign ri = rad_s4;
			assign mi = '0;
			assign oi = '0;
			assign qi = q_s4;
		end else begin : g_next
			assign ri = rad_s5[k-1];
			assign mi = rem_s5[k-1];
			assign oi = root_s5[k-1];
			assign qi = q_s5[k-1];
		end

		assign mn = {mi[svang_pkg::CREM_W-3:0], ri[svang_pkg::CRAD_W-1 -: 2]};
		assign tr = {oi, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s5[k] <= {ri[svang_pkg::CRAD_W-3:0], 2'b00};
				q_s5[k]   <= qi;
				if (mn >= tr) begin
					rem_s5[k]  <= mn - tr;
					root_s5[k] <= {oi[svang_pkg::CROOT_W-2:0], 1'b1};
				end else begin
					rem_s5[k]  <= mn;
					root_s5[k] <= {oi[svang_pkg::CROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	for (genvar i = 0; i < svang_pkg::CORDIC_STEPS; i++) begin : g_cordic
		logic signed [svang_pkg::CV_W-1:0] xi, yi, xs, ys;
		logic signed [svang_pkg::Z_W-1:0]  zi;

		if (i == 0) begin : g_first
			assign xi = $signed(svang_pkg::CV_W'(q_s5[svang_pkg::CROOT_W-1]));
			assign yi = $signed(svang_pkg::CV_W'(root_s5[svang_pkg::CROOT_W-1]));
			assign zi = '0;
		end else begin : g_next
			assign xi = x_s6[i-1];
			assign yi = y_s6[i-1];
			assign zi = z_s6[i-1];
		end

		assign xs = xi >>> i;
		assign ys = yi >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				if (!yi[svang_pkg::CV_W-1]) begin
					x_s6[i] <= xi + ys;
					y_s6[i] <= yi - xs;
					z_s6[i] <= zi + svang_pkg::step_angle(5'(i));
				end else begin
					x_s6[i] <= xi - ys;
					y_s6[i] <= yi + xs;
					z_s6[i] <= zi - svang_pkg::step_angle(5'(i));
				end
			end
		end
	end

	assign zf  = z_s6[svang_pkg::CORDIC_STEPS-1];
	assign zc  = zf[svang_pkg::Z_W-1] ? '0 : zf[svang_pkg::Z_W-2:0];
	assign deg = prod_s7[svang_pkg::PROD_W-1:16];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s7 <= zc * svang_pkg::SCALE;
			if (deg > (svang_pkg::PROD_W-16)'(svang_pkg::ANGLE_MAX)) begin
				angle <= svang_pkg::ANGLE_MAX;
			end else begin
				angle <= svang_pkg::ANGLE_W'(deg);
			end
		end
	end

endmodule

/* hdl/sun_vector_angles.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sun_vector_angles
// Direction cosine angles of a sun vector from five light sensor samples.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one set of five samples. Output
// channel: out_valid / out_stall carry the five angles in hundredths of a
// degree (0..9000). A transfer happens when valid is high and stall is low.
// The block is one pipeline: 2 stages of squares and sum, 20 stages of
// magnitude square root, 1 divisor stage, a ratio divider of 16 stages,
// 2 stages for the complement radicand, 17 square root stages, 17 CORDIC
// stages and 2 stages of scaling. It takes one sample set per cycle while
// the receiver does not stall; each divider or square root stage produces
// one bit and each CORDIC stage one rotation.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// Bubbles travel as cleared valid bits.
// Reset clears all valid bits; out_valid is low until the first result.
// ----------------------------------------------------------------------------
module sun_vector_angles (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [svang_pkg::SAMPLE_BITS-1:0]   sample_pos_x,
	input  logic [svang_pkg::SAMPLE_BITS-1:0]   sample_pos_y,
	input  logic [svang_pkg::SAMPLE_BITS-1:0]   sample_pos_z,
	input  logic [svang_pkg::SAMPLE_BITS-1:0]   sample_neg_x,
	input  logic [svang_pkg::SAMPLE_BITS-1:0]   sample_neg_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [svang_pkg::ANGLE_W-1:0]       angle_pos_x,
	output logic [svang_pkg::ANGLE_W-1:0]       angle_pos_y,
	output logic [svang_pkg::ANGLE_W-1:0]       angle_pos_z,
	output logic [svang_pkg::ANGLE_W-1:0]       angle_neg_x,
	output logic [svang_pkg::ANGLE_W-1:0]       angle_neg_y
);

	logic                                 en;
	svang_pkg::sample_vec_t               smp;
	svang_pkg::mag_out_t                  mo;
	logic [svang_pkg::ANGLE_W-1:0]        ang [svang_pkg::LANES];
	logic                                 vld_s8 [svang_pkg::LANE_LAT];

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	assign smp[0] = sample_pos_x;
	assign smp[1] = sample_pos_y;
	assign smp[2] = sample_pos_z;
	assign smp[3] = sample_neg_x;
	assign smp[4] = sample_neg_y;

	svang_mag u_mag (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (in_valid),
		.smp    (smp),
		.mo     (mo)
	);

	for (genvar n = 0; n < svang_pkg::LANES; n++) begin : g_lane
		svang_lane u_lane (
			.clk   (clk),
			.en    (en),
			.root  (mo.root),
			.smp   (mo.smp[n]),
			.angle (ang[n])
		);
	end

	for (genvar v = 0; v < svang_pkg::LANE_LAT; v++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s8[v] <= 1'b0;
			end else if (en) begin
				vld_s8[v] <= (v == 0) ? mo.vld : vld_s8[(v == 0) ? 0 : v-1];
			end
		end
	end

	assign out_valid   = vld_s8[svang_pkg::LANE_LAT-1];
	assign angle_pos_x = ang[0];
	assign angle_pos_y = ang[1];
	assign angle_pos_z = ang[2];
	assign angle_neg_x = ang[3];
	assign angle_neg_y = ang[4];

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle_pos_x <= svang_pkg::ANGLE_MAX && angle_pos_y <= svang_pkg::ANGLE_MAX
		&& angle_pos_z <= svang_pkg::ANGLE_MAX && angle_neg_x <= svang_pkg::ANGLE_MAX
		&& angle_neg_y <= svang_pkg::ANGLE_MAX)
		else $error("angle above 90 degrees");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	a_hold_inner: assert property (@(posedge clk) disable iff (!arst_n)
		(mo.vld && in_stall) |=> mo.vld)
		else $error("pipeline item lost during stall");

endmodule

/* bench/sun_vector_angles_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sun_vector_angles_test
// Self-checking bench for the sun vector angle pipeline. A directed table of
// sample sets (zero, full scale, single sensors, bit patterns) is followed by
// random sets sent in bursts against a randomly stalling receiver, with one
// long receiver hold that backs the pipeline up. Each result transfer is
// compared lane by lane with typed angles or a fixed point angle predictor.
// ----------------------------------------------------------------------------
module sun_vector_angles_test;

	localparam int N_RANDOM   = 440;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_LEN   = 300;

	typedef logic [4:0][svang_pkg::SAMPLE_BITS-1:0] set_t;
	typedef logic [4:0][svang_pkg::ANGLE_W-1:0] angles_t;
	typedef struct packed {
		set_t    smp;
		logic    typed;
		angles_t ang;
	} row_t;

	localparam longint ATAN_TAB [svang_pkg::CORDIC_STEPS] = '{51472, 30386, 16055, 8150,
		4091, 2047, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

	logic clk, arst_n, in_valid, in_stall, out_valid, out_stall;
	set_t smp;
	angles_t ang;

	angles_t angles_due[$];
	int errors, sets_sent, sets_checked, idle_cycles;
	bit hold_done;

	sun_vector_angles dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_pos_x(smp[0]), .sample_pos_y(smp[1]), .sample_pos_z(smp[2]),
		.sample_neg_x(smp[3]), .sample_neg_y(smp[4]),
		.out_valid(out_valid), .out_stall(out_stall),
		.angle_pos_x(ang[0]), .angle_pos_y(ang[1]), .angle_pos_z(ang[2]),
		.angle_neg_x(ang[3]), .angle_neg_y(ang[4])
	);

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [svang_pkg::ANGLE_W-1:0] arc_cos_hundredths(
			longint unsigned s, longint unsigned r);
		longint unsigned q, c, prod;
		longint x, y, z, nx, ny;
		q = (s << 24) / r;
		if (q > 65535)
			q = 65535;
		c = int_sqrt((64'd1 << 32) - q * q);
		x = q;
		y = c;
		z = 0;
		for (int i = 0; i < svang_pkg::CORDIC_STEPS; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += ATAN_TAB[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= ATAN_TAB[i];
			end
			x = nx;
			y = ny;
		end
		if (z < 0)
			z = 0;
		prod = (longint'(z) * 5729) >> 16;
		if (prod > 9000)
			prod = 9000;
		return prod[svang_pkg::ANGLE_W-1:0];
	endfunction

	function automatic angles_t sun_angles(set_t s);
		longint unsigned sx, sy, sum, r;
		angles_t a;
		sx = s[0] + s[3];
		sy = s[1] + s[4];
		sum = sx * sx + sy * sy + longint'(s[2]) * s[2];
		r = int_sqrt(sum << 16) + 256;
		for (int k = 0; k < 5; k++)
			a[k] = arc_cos_hundredths(s[k], r);
		return a;
	endfunction

	row_t directed [] = '{
		'{'{10'd0, 10'd0, 10'd0, 10'd0, 10'd0}, 1'b1,
			'{14'd8999, 14'd8999, 14'd8999, 14'd8999, 14'd8999}},
		'{'{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023}, 1'b0, '0},
		'{'{10'd0, 10'd0, 10'd0, 10'd0, 10'd1023}, 1'b0, '0},
		'{'{10'd0, 10'd0, 10'd0, 10'd1023, 10'd0}, 1'b0, '0},
		'{'{10'd0, 10'd0, 10'd1023, 10'd0, 10'd0}, 1'b0, '0},
		'{'{10'd0, 10'd1023, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
		'{'{10'd1023, 10'd0, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
		'{'{10'd1, 10'd0, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
		'{'{10'd0, 10'd0, 10'd1, 10'd0, 10'd0}, 1'b0, '0},
		'{'{10'd1, 10'd1, 10'd1, 10'd1, 10'd1}, 1'b0, '0},
		'{'{10'd1023, 10'd0, 10'd0, 10'd1023, 10'd0}, 1'b0, '0},
		'{'{10'd0, 10'd1023, 10'd0, 10'd0, 10'd1023}, 1'b0, '0},
		'{'{10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA}, 1'b0, '0},
		'{'{10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155}, 1'b0, '0},
		'{'{10'd512, 10'd0, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
		'{'{10'd1023, 10'd1, 10'd1, 10'd1, 10'd1}, 1'b0, '0},
		'{'{10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1023}, 1'b0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send_set(set_t s, logic typed, angles_t a);
		in_valid <= 1'b1;
		smp <= s;
		do @(posedge clk); while (in_stall);
		angles_due.push_back(typed ? a : sun_angles(s));
		sets_sent++;
	endtask

	function automatic logic [svang_pkg::SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return svang_pkg::SAMPLE_BITS'($urandom_range(0, 15));
			default: return svang_pkg::SAMPLE_BITS'($urandom);
		endcase
	endfunction

	initial begin
		int burst;
		set_t s;
		arst_n = 1'b0;
		in_valid = 1'b0;
		smp = '0;
		errors = 0;
		sets_sent = 0;
		burst = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_set(directed[i].smp, directed[i].typed, directed[i].ang);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				if ($urandom_range(0, 2) != 0) begin
					in_valid <= 1'b0;
					smp <= set_t'({$urandom, $urandom});
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			end
			burst--;
			for (int k = 0; k < 5; k++)
				s[k] = rand_sample();
			send_set(s, 1'b0, '0);
		end
		in_valid <= 1'b0;
		while (angles_due.size() != 0)
			@(posedge clk);
		repeat (svang_pkg::MAG_LAT + svang_pkg::LANE_LAT + 20) @(posedge clk);
		$display("Sent %0d sample sets (%0d directed), checked %0d angle results,",
			sets_sent, directed.size(), sets_checked);
		$display("with bursty input, random output stalls and a %0d-cycle backpressure hold.",
			HOLD_LEN);
		if (errors == 0 && angles_due.size() == 0)
			$display("sun_vector_angles_test: PASS");
		else
			$display("sun_vector_angles_test: FAIL");
		$finish;
	end

	// receiver stall pattern, with one long hold once results are flowing
	initial begin
		int mode;
		out_stall = 1'b0;
		hold_done = 1'b0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (!hold_done && sets_checked >= 150) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
			end
			if ($urandom_range(0, 63) == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= $urandom_range(0, 1);
			endcase
		end
	end

	always @(posedge clk) begin
		angles_t want;
		if (arst_n && out_valid && !out_stall) begin
			sets_checked++;
			if (angles_due.size() == 0) begin
				$display("%0t: unexpected result transfer, actual %p", $time, ang);
				errors++;
			end else begin
				want = angles_due.pop_front();
				for (int k = 0; k < 5; k++)
					if (ang[k] !== want[k]) begin
						$display("%0t: lane %0d angle mismatch, expected %0d actual %0d",
							$time, k, want[k], ang[k]);
						errors++;
					end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("sun_vector_angles_test: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
